@@ hw/rtl/tli_pkg.sv @@
// tli_pkg: shared constants and types for the table linear interpolator
// depends on nothing; used by tli_div and table_linear_interpolator_core
`timescale 1ns / 1ps

package tli_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int DATA_W      = 32;
    localparam int SIZE_W      = 7;
    localparam int INDEX_W     = 6;
    localparam int KIND_W      = 3;

    localparam int DIV_STEPS   = DATA_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [KIND_W-1:0] KIND_EXACT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INTERP = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLAMP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd4;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_EVAL = 6'b000100,
        S_MUL  = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [2*DATA_W-1:0]   dividend;
        logic [DATA_W-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DATA_W-1:0]     quotient;
    } div_rsp_t;

endpackage

@@ hw/rtl/tli_ram.sv @@
// tli_ram: generic single write port, single read port ram with registered read
// no package dependencies
`timescale 1ns / 1ps

module tli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/tli_div.sv @@
// tli_div: restoring divider, one quotient bit per cycle
// depends on tli_pkg; quotient must fit DATA_W bits (high half below divisor)
`timescale 1ns / 1ps

module tli_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  tli_pkg::div_req_t req,
    output tli_pkg::div_rsp_t rsp
);

    import tli_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    low_reg, low_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    divisor_reg, divisor_next;

    logic [DATA_W:0]      shifted;
    logic [DATA_W:0]      diff;

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        low_next     = low_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        shifted      = {rem_reg, low_reg[DATA_W-1]};
        diff         = shifted - {1'b0, divisor_reg};
        if (req.start) begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            rem_next     = req.dividend[2*DATA_W-1:DATA_W];
            low_next     = req.dividend[DATA_W-1:0];
            divisor_next = req.divisor;
        end else if (busy_reg) begin
            low_next = {low_reg[DATA_W-2:0], 1'b0};
            if (!diff[DATA_W]) begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg     <= rem_next;
        low_reg     <= low_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ hw/rtl/table_linear_interpolator_core.sv @@
// table_linear_interpolator_core: top level of the table linear interpolator
// depends on tli_pkg, tli_ram and tli_div
//
// usage
//   s_ channel (valid/ready) carries one item: s_cmd selects a table write
//   (s_entry_index, s_point_x, s_point_y) or a query (s_query_x).
//   m_ channel (valid/ready) returns one item per input item: m_value, m_kind.
//   cfg_wr_en/cfg_wr_data set the number of table points a query scans;
//   write it only while no item is in flight.
// sequencing and throughput
//   a write item goes through S_DONE into the output register.
//   a query over n points (n = table_size, at most TABLE_DEPTH) scans the
//   table with one table read per cycle, then evaluates in S_EVAL, and when
//   it interpolates goes through a multiply state and a 32-step divider.
//   one item is worked on at a time; s_ready is high only when idle.
// reset and stall
//   aresetn (synchronous, active low) clears the sequencer, the output valid
//   and table_size; table contents are not cleared and must be written
//   before they are queried. a new item is taken while a result still waits
//   on m_ready; the next result waits until the output register is free.
`timescale 1ns / 1ps

module table_linear_interpolator_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [tli_pkg::SIZE_W-1:0]         cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_cmd,
    input  logic [tli_pkg::INDEX_W-1:0]        s_entry_index,
    input  logic signed [tli_pkg::DATA_W-1:0]  s_point_x,
    input  logic signed [tli_pkg::DATA_W-1:0]  s_point_y,
    input  logic signed [tli_pkg::DATA_W-1:0]  s_query_x,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [tli_pkg::DATA_W-1:0]  m_value,
    output logic [tli_pkg::KIND_W-1:0]         m_kind
);

    import tli_pkg::*;

    state_t                   state_reg, state_next;
    logic [SIZE_W-1:0]        table_size_reg;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [CNT_W-1:0]         iss_reg, iss_next;
    logic                     rdv_reg, rdv_next;
    logic signed [DATA_W-1:0] q_reg, q_next;
    logic                     have_lo_reg, have_lo_next;
    logic                     have_hi_reg, have_hi_next;
    logic signed [DATA_W-1:0] lo_x_reg, lo_x_next, lo_y_reg, lo_y_next;
    logic signed [DATA_W-1:0] hi_x_reg, hi_x_next, hi_y_reg, hi_y_next;
    logic [DATA_W-1:0]        dx_reg, dx_next, span_reg, span_next, mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic signed [DATA_W-1:0] res_value_reg, res_value_next;
    logic [KIND_W-1:0]        res_kind_reg, res_kind_next;
    logic                     m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] m_value_reg, m_value_next;
    logic [KIND_W-1:0]        m_kind_reg, m_kind_next;

    logic                     s_fire;
    logic                     ram_wr_en;
    logic                     ram_rd_en;
    logic [2*DATA_W-1:0]      ram_rd_data;
    logic signed [DATA_W-1:0] rd_x, rd_y;
    logic signed [DATA_W:0]   dy;
    logic signed [DATA_W:0]   sum;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    assign s_fire    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign ram_wr_en = s_fire && (s_cmd == CMD_WRITE)
                       && (32'(s_entry_index) < TABLE_DEPTH);
    assign ram_rd_en = (state_reg == S_SCAN) && (iss_reg < n_reg);
    assign rd_x      = $signed(ram_rd_data[2*DATA_W-1:DATA_W]);
    assign rd_y      = $signed(ram_rd_data[DATA_W-1:0]);
    assign dy        = {hi_y_reg[DATA_W-1], hi_y_reg} - {lo_y_reg[DATA_W-1], lo_y_reg};
    assign sum       = neg_reg ? ({lo_y_reg[DATA_W-1], lo_y_reg} - {1'b0, div_rsp.quotient})
                               : ({lo_y_reg[DATA_W-1], lo_y_reg} + {1'b0, div_rsp.quotient});

    assign div_req.start    = (state_reg == S_MUL);
    assign div_req.dividend = dx_reg * mag_reg;
    assign div_req.divisor  = span_reg;

    tli_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ADDR_W'(s_entry_index)),
        .wr_data ({s_point_x, s_point_y}),
        .rd_en   (ram_rd_en),
        .rd_addr (iss_reg[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    tli_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        iss_next       = iss_reg;
        rdv_next       = 1'b0;
        q_next         = q_reg;
        have_lo_next   = have_lo_reg;
        have_hi_next   = have_hi_reg;
        lo_x_next      = lo_x_reg;
        lo_y_next      = lo_y_reg;
        hi_x_next      = hi_x_reg;
        hi_y_next      = hi_y_reg;
        dx_next        = dx_reg;
        span_next      = span_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        res_value_next = res_value_reg;
        res_kind_next  = res_kind_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_value_next   = m_value_reg;
        m_kind_next    = m_kind_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_cmd == CMD_WRITE) begin
                        res_value_next = '0;
                        res_kind_next  = KIND_WRITE;
                        state_next     = S_DONE;
                    end else begin
                        q_next       = s_query_x;
                        iss_next     = '0;
                        have_lo_next = 1'b0;
                        have_hi_next = 1'b0;
                        if (32'(table_size_reg) > TABLE_DEPTH) begin
                            n_next = CNT_W'(TABLE_DEPTH);
                        end else begin
                            n_next = CNT_W'(table_size_reg);
                        end
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (ram_rd_en) begin
                    iss_next = iss_reg + 1'b1;
                    rdv_next = 1'b1;
                end
                if (rdv_reg) begin
                    if (rd_x == q_reg) begin
                        res_value_next = rd_y;
                        res_kind_next  = KIND_EXACT;
                        state_next     = S_DONE;
                    end else if (rd_x > q_reg) begin
                        if (!have_hi_reg || rd_x < hi_x_reg) begin
                            have_hi_next = 1'b1;
                            hi_x_next    = rd_x;
                            hi_y_next    = rd_y;
                        end
                    end else begin
                        if (!have_lo_reg || rd_x > lo_x_reg) begin
                            have_lo_next = 1'b1;
                            lo_x_next    = rd_x;
                            lo_y_next    = rd_y;
                        end
                    end
                end
                if (!(rdv_reg && rd_x == q_reg) && !ram_rd_en && (rdv_reg || n_reg == '0)) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (have_lo_reg && have_hi_reg) begin
                    dx_next    = DATA_W'(q_reg - lo_x_reg);
                    span_next  = DATA_W'(hi_x_reg - lo_x_reg);
                    neg_next   = dy[DATA_W];
                    mag_next   = dy[DATA_W] ? DATA_W'(-dy) : DATA_W'(dy);
                    state_next = S_MUL;
                end else if (have_lo_reg) begin
                    res_value_next = lo_y_reg;
                    res_kind_next  = KIND_CLAMP;
                    state_next     = S_DONE;
                end else if (have_hi_reg) begin
                    res_value_next = hi_y_reg;
                    res_kind_next  = KIND_CLAMP;
                    state_next     = S_DONE;
                end else begin
                    res_value_next = '0;
                    res_kind_next  = KIND_EMPTY;
                    state_next     = S_DONE;
                end
            end
            S_MUL: begin
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (sum[DATA_W] != sum[DATA_W-1]) begin
                        res_value_next = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                                     : {1'b0, {(DATA_W-1){1'b1}}};
                    end else begin
                        res_value_next = sum[DATA_W-1:0];
                    end
                    res_kind_next = KIND_INTERP;
                    state_next    = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_value_next = res_value_reg;
                    m_kind_next  = res_kind_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            table_size_reg <= '0;
            m_valid_reg    <= 1'b0;
            rdv_reg        <= 1'b0;
            iss_reg        <= '0;
            n_reg          <= '0;
            have_lo_reg    <= 1'b0;
            have_hi_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            rdv_reg     <= rdv_next;
            iss_reg     <= iss_next;
            n_reg       <= n_next;
            have_lo_reg <= have_lo_next;
            have_hi_reg <= have_hi_next;
            if (cfg_wr_en) begin
                table_size_reg <= cfg_wr_data;
            end
        end
        q_reg         <= q_next;
        lo_x_reg      <= lo_x_next;
        lo_y_reg      <= lo_y_next;
        hi_x_reg      <= hi_x_next;
        hi_y_reg      <= hi_y_next;
        dx_reg        <= dx_next;
        span_reg      <= span_next;
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        res_value_reg <= res_value_next;
        res_kind_reg  <= res_kind_next;
        m_value_reg   <= m_value_next;
        m_kind_reg    <= m_kind_next;
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;
    assign m_kind  = m_kind_reg;

    // interpolated value stays between the two bracketing ordinates
    a_interp_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && div_rsp.done) |->
            ((sum >= $signed({lo_y_reg[DATA_W-1], lo_y_reg})
              || sum >= $signed({hi_y_reg[DATA_W-1], hi_y_reg}))
             && (sum <= $signed({lo_y_reg[DATA_W-1], lo_y_reg})
                 || sum <= $signed({hi_y_reg[DATA_W-1], hi_y_reg}))))
        else $error("interpolated value outside bracketing points");

    // divider only finishes while the sequencer waits on it
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider done outside divide state");

    // scan never reads past the clamped table size
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (iss_reg <= n_reg && 32'(n_reg) <= TABLE_DEPTH))
        else $error("table scan beyond table size");

    // an accepted item keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("item accepted while previous item in flight");

endmodule

@@ tb/table_linear_interpolator_core_test.sv @@
// table_linear_interpolator_core_test: self-checking testbench for the table interpolator
// keeps its own copy of the point table and scan size, predicts every result item and
// checks it; depends on tli_pkg and table_linear_interpolator_core
`timescale 1ns / 1ps

module table_linear_interpolator_core_test;
    import tli_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 120;
    localparam int PHASE_ITEMS = 100;
    localparam int PHASES      = 12;

    typedef struct packed {
        logic               cmd;
        logic [INDEX_W-1:0] idx;
        logic [DATA_W-1:0]  px;
        logic [DATA_W-1:0]  py;
        logic [DATA_W-1:0]  qx;
    } table_op_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [KIND_W-1:0] kind;
    } answer_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [SIZE_W-1:0]         cfg_wr_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_cmd = CMD_WRITE;
    logic [INDEX_W-1:0]        s_entry_index = '0;
    logic signed [DATA_W-1:0]  s_point_x = '0;
    logic signed [DATA_W-1:0]  s_point_y = '0;
    logic signed [DATA_W-1:0]  s_query_x = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [DATA_W-1:0]  m_value;
    logic [KIND_W-1:0]         m_kind;

    table_op_t table_ops[$];
    answer_t   predicted_answers[$];

    logic signed [DATA_W-1:0] tab_x [TABLE_DEPTH];
    logic signed [DATA_W-1:0] tab_y [TABLE_DEPTH];
    logic signed [DATA_W-1:0] gen_x [TABLE_DEPTH];
    logic [SIZE_W-1:0]        scan_size = '0;

    int  n_issued = 0;
    int  n_accepted = 0;
    int  err_cnt = 0;
    int  send_wait = 0;
    int  recv_wait = 0;
    int  hold_left = 0;
    int  hold_seen = 0;
    int  hold_asks = 0;
    int  quiet_cycles = 0;
    bit  send_idle_on = 1'b0;
    bit  recv_idle_on = 1'b0;
    int  phase_size [PHASES] = '{64, 127, 3, 1, 2, 8, 65, 0, 5, 16, 64, 12};

    table_linear_interpolator_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_entry_index (s_entry_index),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .s_query_x     (s_query_x),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .m_kind        (m_kind)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic answer_t predict_answer(table_op_t op);
        answer_t   ans;
        longint    q, xj, xl, xh, yl, yh, dy, delta, sum;
        bit [63:0] dx, span, mag, quo;
        int        n, lo, hi;
        bit        have_lo, have_hi;
        ans.value = '0;
        ans.kind = KIND_EMPTY;
        have_lo = 1'b0;
        have_hi = 1'b0;
        lo = 0;
        hi = 0;
        if (op.cmd == CMD_WRITE) begin
            tab_x[op.idx] = op.px;
            tab_y[op.idx] = op.py;
            ans.kind = KIND_WRITE;
            return ans;
        end
        q = $signed(op.qx);
        n = (scan_size > TABLE_DEPTH) ? TABLE_DEPTH : int'(scan_size);
        for (int j = 0; j < n; j++) begin
            xj = tab_x[j];
            if (xj == q) begin
                ans.value = tab_y[j];
                ans.kind = KIND_EXACT;
                return ans;
            end
            if (xj > q) begin
                if (!have_hi || xj < tab_x[hi]) begin
                    hi = j;
                    have_hi = 1'b1;
                end
            end else if (!have_lo || xj > tab_x[lo]) begin
                lo = j;
                have_lo = 1'b1;
            end
        end
        if (have_lo && have_hi) begin
            xl = tab_x[lo];
            xh = tab_x[hi];
            yl = tab_y[lo];
            yh = tab_y[hi];
            dx = q - xl;
            span = xh - xl;
            dy = yh - yl;
            mag = (dy < 0) ? -dy : dy;
            quo = (dx * mag) / span;
            delta = (dy < 0) ? -$signed(quo) : $signed(quo);
            sum = yl + delta;
            if (sum > 64'sd2147483647) begin
                sum = 64'sd2147483647;
            end else if (sum < -64'sd2147483648) begin
                sum = -64'sd2147483648;
            end
            ans.value = sum[31:0];
            ans.kind = KIND_INTERP;
        end else if (have_lo) begin
            ans.value = tab_y[lo];
            ans.kind = KIND_CLAMP;
        end else if (have_hi) begin
            ans.value = tab_y[hi];
            ans.kind = KIND_CLAMP;
        end
        return ans;
    endfunction

    function automatic logic [DATA_W-1:0] draw_abscissa();
        int unsigned mode;
        mode = $urandom_range(99);
        if (mode < 30) return $urandom;
        if (mode < 50) return (int'($urandom_range(6)) - 3) * 65536;
        if (mode < 85) return int'($urandom_range(2000)) - 1000;
        case ($urandom_range(2))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            default: return '0;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] draw_ordinate();
        int unsigned mode;
        mode = $urandom_range(99);
        if (mode < 50) return $urandom;
        if (mode < 65) return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        return int'($urandom_range(200000)) - 100000;
    endfunction

    function automatic logic [DATA_W-1:0] draw_query(int n);
        int unsigned mode;
        longint      a, b;
        mode = $urandom_range(99);
        if (n > 0) begin
            a = gen_x[$urandom_range(n - 1)];
            b = gen_x[$urandom_range(n - 1)];
            if (mode < 35) return a[31:0];
            if (mode < 55) return $urandom_range(1) ? a[31:0] + 1 : a[31:0] - 1;
            if (mode < 70) return DATA_W'((a + b) >>> 1);
        end
        if (mode < 90) return $urandom;
        case ($urandom_range(2))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            default: return '0;
        endcase
    endfunction

    task automatic queue_write(logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] px,
                               logic [DATA_W-1:0] py);
        table_op_t op;
        op.cmd = CMD_WRITE;
        op.idx = idx;
        op.px = px;
        op.py = py;
        op.qx = $urandom;
        gen_x[idx] = px;
        table_ops.push_back(op);
        n_issued++;
    endtask

    task automatic queue_query(logic [DATA_W-1:0] qx);
        table_op_t op;
        op.cmd = CMD_QUERY;
        op.idx = INDEX_W'($urandom);
        op.px = $urandom;
        op.py = $urandom;
        op.qx = qx;
        table_ops.push_back(op);
        n_issued++;
    endtask

    task automatic wait_idle();
        @(posedge aclk);
        while (!(n_accepted == n_issued && predicted_answers.size() == 0)) begin
            @(posedge aclk);
        end
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_scan_size(logic [SIZE_W-1:0] size);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= size;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        scan_size = size;
    endtask

    task automatic note_error(string msg);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("%t: %s", $realtime, msg);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        table_op_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_valid && s_ready) begin
                predicted_answers.push_back(predict_answer(
                    '{s_cmd, s_entry_index, s_point_x, s_point_y, s_query_x}));
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_valid <= 1'b0;
                end else if (table_ops.size() > 0) begin
                    req = table_ops.pop_front();
                    s_valid <= 1'b1;
                    s_cmd <= req.cmd;
                    s_entry_index <= req.idx;
                    s_point_x <= req.px;
                    s_point_y <= req.py;
                    s_query_x <= req.qx;
                    send_wait = send_idle_on ? $urandom_range(16) : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_answers.size() == 0) begin
                    note_error($sformatf("unexpected item value %h kind %0d", m_value, m_kind));
                end else begin
                    want = predicted_answers.pop_front();
                    if (m_value !== want.value || m_kind !== want.kind) begin
                        note_error($sformatf("got value %h kind %0d, expected value %h kind %0d",
                                             m_value, m_kind, want.value, want.kind));
                    end
                end
                recv_wait = recv_idle_on ? $urandom_range(16) : 0;
            end
            if (hold_seen != hold_asks) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int n_scan;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table, then corner points
        queue_query('0);
        queue_query(32'h7fff_ffff);
        queue_write(0, 32'h8000_0000, 32'h7fff_ffff);
        queue_write(1, 32'h7fff_ffff, 32'h8000_0000);
        queue_write(2, 0, 32'h0001_0000);
        queue_write(3, 0, 5);
        queue_write(63, 100, 200);
        set_scan_size(1);
        queue_query(32'h8000_0000);
        queue_query('0);
        set_scan_size(2);
        queue_query('0);
        queue_query(32'h7fff_ffff);
        queue_query(32'h8000_0001);
        set_scan_size(4);
        queue_query('0);
        queue_query(1);
        queue_query(-1);
        queue_write(0, -100, 7);
        queue_query(-200);
        queue_query(32'h8000_0000);
        queue_query(-50);

        for (int s = 4; s < TABLE_DEPTH - 1; s++) begin
            queue_write(INDEX_W'(s), draw_abscissa(), draw_ordinate());
        end

        for (int p = 0; p < PHASES; p++) begin
            set_scan_size(SIZE_W'(phase_size[p]));
            n_scan = (phase_size[p] > TABLE_DEPTH) ? TABLE_DEPTH : phase_size[p];
            send_idle_on <= (p % 4 == 1) || (p % 4 == 3);
            recv_idle_on <= (p % 4 >= 2);
            if (p == 2 || p == 8) begin
                hold_asks <= hold_asks + 1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(99) < 30) begin
                    queue_write(INDEX_W'($urandom_range(TABLE_DEPTH - 1)), draw_abscissa(),
                                draw_ordinate());
                end else begin
                    queue_query(draw_query(n_scan));
                end
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/tli_pkg.sv
hw/rtl/tli_ram.sv
hw/rtl/tli_div.sv
hw/rtl/table_linear_interpolator_core.sv
tb/table_linear_interpolator_core_test.sv
